// ----- rtl/pbrr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the priority bitmap round-robin scheduler.
package pbrr_pkg;
	localparam int MaxTasks   = 32;
	localparam int PrioLevels = 32;
	localparam int TW = $clog2(MaxTasks);
	localparam int PW = $clog2(PrioLevels);

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_STATUS = 3'd1;
	localparam logic [2:0] ACT_WAKE   = 3'd2;
	localparam logic [2:0] ACT_EXIT   = 3'd3;
	localparam logic [2:0] ACT_RESCH  = 3'd4;
	localparam logic [2:0] ACT_RUN    = 3'd5;

	localparam logic [1:0] ST_STOPPED = 2'd0;
	localparam logic [1:0] ST_WAITING = 2'd2;
	localparam logic [1:0] ST_RUNNING = 2'd3;

	typedef struct packed {
		logic [2:0] action;
		logic [4:0] task_id;
		logic [1:0] new_status;
		logic [4:0] priority_req;
	} in_word_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       ok;
		logic       switched;
		logic       active_valid;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture input word
		logic decide;  // resolve lookups
		logic commit;  // write tables, build result
	} dp_cmd_t;
endpackage

// ----- rtl/priority_bitmap_round_robin_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Priority bitmap scheduler with one round-robin run queue per level. One word is
// handled at a time: after the accepting edge come a table lookup state and a table
// update state that registers the result word. The result holds until taken, and the
// next word is accepted in the cycle after it leaves. Tables are clear at reset.
module priority_bitmap_round_robin_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pbrr_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pbrr_pkg::out_word_t out_data
);
	import pbrr_pkg::*;

	dp_cmd_t cmd;

	pbrr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
	);

	pbrr_datapath u_dp (
		.clk, .arst_n, .cmd, .in_word(in_data), .res(out_data)
	);
endmodule

// ----- rtl/pbrr_datapath.sv -----
`timescale 1ns / 1ps
// Task tables, run queues and the per-action update logic.
module pbrr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  pbrr_pkg::dp_cmd_t  cmd,
	input  pbrr_pkg::in_word_t in_word,
	output pbrr_pkg::out_word_t res
);
	import pbrr_pkg::*;

	logic [MaxTasks-1:0]       used_q;
	logic [PW-1:0]             prio_q [MaxTasks];
	logic [1:0]                stat_q [MaxTasks];
	logic [TW-1:0]             next_q [MaxTasks];
	logic [TW-1:0]             prevl_q[MaxTasks];
	logic [TW-1:0]             head_q [PrioLevels];
	logic [TW-1:0]             tail_q [PrioLevels];
	logic [PrioLevels-1:0]     bmp_q;
	logic [TW-1:0]             act_q;
	logic                      actp_q, pend_q;
	in_word_t                  w_q;

	// decided values, registered between decide and commit
	logic [TW-1:0]  t_s1;     // addressed task
	logic           tok_s1;   // task valid / found
	logic [PW-1:0]  p_s1;     // its priority or picked level
	logic [TW-1:0]  th_s1, tt_s1, tn_s1, tp_s1;
	logic [1:0]     tst_s1;

	logic [TW-1:0]  free_c, t_c;
	logic           free_ok_c, tok_c;
	logic [PW-1:0]  top_c, p_c;

	always_comb begin
		free_c = '0;
		free_ok_c = 1'b0;
		for (int i = MaxTasks-1; i >= 0; i--)
			if (!used_q[i]) begin
				free_c = TW'(i);
				free_ok_c = 1'b1;
			end
		top_c = '0;
		for (int i = 0; i < PrioLevels; i++)
			if (bmp_q[i]) top_c = PW'(i);
		t_c = '0;
		tok_c = 1'b0;
		p_c = '0;
		case (w_q.action)
			ACT_STATUS, ACT_WAKE: begin
				t_c = TW'(w_q.task_id);
				tok_c = ({27'd0, w_q.task_id} < 32'(MaxTasks)) && used_q[t_c];
				p_c = prio_q[t_c];
			end
			ACT_EXIT: begin
				t_c = act_q;
				tok_c = actp_q;
				p_c = prio_q[t_c];
			end
			ACT_RUN: begin
				p_c = top_c;
				t_c = head_q[top_c];
				tok_c = |bmp_q;
			end
			ACT_ADD: begin
				t_c = free_c;
				tok_c = free_ok_c;
				p_c = (32'(w_q.priority_req) >= 32'(PrioLevels)) ? PW'(PrioLevels-1)
					: PW'(w_q.priority_req);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) w_q <= in_word;
		if (cmd.decide) begin
			t_s1 <= t_c; tok_s1 <= tok_c; p_s1 <= p_c;
			th_s1 <= head_q[p_c]; tt_s1 <= tail_q[p_c];
			tn_s1 <= next_q[t_c]; tp_s1 <= prevl_q[t_c];
			tst_s1 <= stat_q[t_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; bmp_q <= '0; act_q <= '0; actp_q <= 1'b0; pend_q <= 1'b0;
			res <= '0;
			for (int i = 0; i < MaxTasks; i++) begin
				prio_q[i] <= '0; stat_q[i] <= '0; next_q[i] <= '0; prevl_q[i] <= '0;
			end
			for (int i = 0; i < PrioLevels; i++) begin
				head_q[i] <= '0; tail_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			logic push, remove, on;
			logic [4:0] slot;
			logic okv, swv, ap;
			push = 1'b0; remove = 1'b0;
			slot = '0; okv = 1'b0; swv = 1'b0; ap = actp_q;
			on = tst_s1 >= ST_WAITING;
			case (w_q.action)
				ACT_ADD: if (tok_s1) begin
					used_q[t_s1] <= 1'b1; prio_q[t_s1] <= p_s1; stat_q[t_s1] <= ST_STOPPED;
					next_q[t_s1] <= '0; prevl_q[t_s1] <= '0;
					slot = 5'(t_s1); okv = 1'b1;
				end
				ACT_STATUS: if (tok_s1) begin
					if (w_q.new_status >= ST_WAITING) push = !on;
					else remove = on;
					stat_q[t_s1] <= w_q.new_status;
					okv = 1'b1;
				end
				ACT_WAKE: if (tok_s1) begin
					if (!on) begin
						push = 1'b1; stat_q[t_s1] <= ST_WAITING; pend_q <= 1'b1;
					end
					okv = 1'b1;
				end
				ACT_EXIT: if (tok_s1) begin
					used_q[t_s1] <= 1'b0; remove = on; stat_q[t_s1] <= ST_STOPPED;
					slot = 5'(t_s1); actp_q <= 1'b0; ap = 1'b0; pend_q <= 1'b1; okv = 1'b1;
				end
				ACT_RESCH: begin
					pend_q <= 1'b1; okv = 1'b1;
				end
				ACT_RUN: begin
					if (!pend_q) okv = 1'b1;
					else if (tok_s1) begin
						// rotate head to tail
						if (t_s1 != tt_s1) begin
							head_q[p_s1] <= tn_s1;
							next_q[tt_s1] <= t_s1;
							prevl_q[t_s1] <= tt_s1;
							tail_q[p_s1] <= t_s1;
						end
						if (!(actp_q && t_s1 == act_q)) begin
							if (actp_q && stat_q[act_q] == ST_RUNNING && act_q != t_s1)
								stat_q[act_q] <= ST_WAITING;
							stat_q[t_s1] <= ST_RUNNING;
							act_q <= t_s1; actp_q <= 1'b1; ap = 1'b1; swv = 1'b1;
						end
						pend_q <= 1'b0; okv = 1'b1;
					end
					slot = ap ? (swv ? 5'(t_s1) : 5'(act_q)) : 5'd0;
				end
				default: ;
			endcase
			if (push) begin
				if (!bmp_q[p_s1]) begin
					head_q[p_s1] <= t_s1; tail_q[p_s1] <= t_s1; bmp_q[p_s1] <= 1'b1;
				end else begin
					next_q[t_s1] <= th_s1; prevl_q[th_s1] <= t_s1; head_q[p_s1] <= t_s1;
				end
			end
			if (remove) begin
				if (th_s1 == t_s1 && tt_s1 == t_s1) bmp_q[p_s1] <= 1'b0;
				else if (th_s1 == t_s1) head_q[p_s1] <= tn_s1;
				else if (tt_s1 == t_s1) tail_q[p_s1] <= tp_s1;
				else begin
					next_q[tp_s1] <= tn_s1; prevl_q[tn_s1] <= tp_s1;
				end
			end
			res <= '{slot_out: slot, ok: okv, switched: swv, active_valid: ap};
		end
	end
endmodule

// ----- rtl/pbrr_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: load, decide, commit, then hold the result word until taken.
module pbrr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pbrr_pkg::dp_cmd_t cmd
);
	import pbrr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_COMMIT = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

	state_t state_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.decide = state_q == S_DECIDE;
	assign cmd.commit = state_q == S_COMMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule
